### hw/rtl/remv_pkg.sv
// ----------------------------------------------------------------------------
// remv_pkg
// Shared constants and types for the running error mean/variance block.
// ----------------------------------------------------------------------------
package remv_pkg;

    // default word format: Q16.16 in 32 bits
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // sample counter and configuration register widths are fixed
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 32;

    // operations of the shared square/divide unit
    typedef enum logic {
        OP_SQR = 1'b0,
        OP_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctl;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_alu_sts;

endpackage

### hw/rtl/remv_alu.sv
// ----------------------------------------------------------------------------
// remv_alu
// Shared iterative unit: squares a word by shift-and-add or divides a
// double word by a count-width divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module remv_alu #(
    parameter int DATA_WIDTH = remv_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  remv_pkg::t_alu_ctl        i_ctl,
    input  logic [2*DATA_WIDTH-1:0]   i_opa,
    input  logic [remv_pkg::COUNT_W-1:0] i_opb,
    output remv_pkg::t_alu_sts        o_sts,
    output logic [2*DATA_WIDTH-1:0]   o_res
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DATA_WIDTH;
    localparam int CW = remv_pkg::COUNT_W;
    localparam int HW = (DW > CW) ? DW : CW;
    localparam int KW = $clog2(DW);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic                r_ovf, n_ovf;
    logic [KW-1:0]       r_iter, n_iter;
    remv_pkg::t_alu_op   r_op, n_op;
    logic [PW-1:0]       r_acc, n_acc;
    logic [DW-1:0]       r_sh, n_sh;
    logic [DW-1:0]       r_mcand, n_mcand;
    logic [CW-1:0]       r_rem, n_rem;
    logic [CW-1:0]       r_dvs, n_dvs;

    logic [HW-1:0]       w_hi_x;
    logic [HW-1:0]       w_dvs_x;
    logic                w_start_ovf;
    logic [CW:0]         w_trial;
    logic [CW+1:0]       w_diff;
    logic                w_fits;
    logic [PW-1:0]       w_acc_add;
    logic                w_last;

    assign w_hi_x      = HW'(i_opa[PW-1:DW]);
    assign w_dvs_x     = HW'(i_opb);
    // quotient would not fit in one word
    assign w_start_ovf = (w_hi_x >= w_dvs_x);

    assign w_trial   = {r_rem, r_sh[DW-1]};
    assign w_diff    = {1'b0, w_trial} - {2'b00, r_dvs};
    assign w_fits    = ~w_diff[CW+1];
    assign w_acc_add = {r_acc[PW-2:0], 1'b0} + (r_sh[DW-1] ? PW'(r_mcand) : PW'(0));
    assign w_last    = (r_iter == KW'(DW - 1));

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_ovf   = r_ovf;
        n_iter  = r_iter;
        n_op    = r_op;
        n_acc   = r_acc;
        n_sh    = r_sh;
        n_mcand = r_mcand;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        if (i_ctl.start) begin
            n_op   = i_ctl.op;
            n_iter = '0;
            n_ovf  = 1'b0;
            case (i_ctl.op)
                remv_pkg::OP_SQR: begin
                    n_acc   = '0;
                    n_sh    = i_opa[DW-1:0];
                    n_mcand = i_opa[DW-1:0];
                    n_busy  = 1'b1;
                end
                remv_pkg::OP_DIV: begin
                    n_rem = w_hi_x[CW-1:0];
                    n_sh  = i_opa[DW-1:0];
                    n_dvs = i_opb;
                    if (w_start_ovf) begin
                        n_ovf  = 1'b1;
                        n_done = 1'b1;
                        n_busy = 1'b0;
                    end else begin
                        n_busy = 1'b1;
                    end
                end
                default: n_busy = 1'b0;
            endcase
        end else if (r_busy) begin
            case (r_op)
                remv_pkg::OP_SQR: begin
                    n_acc = w_acc_add;
                    n_sh  = {r_sh[DW-2:0], 1'b0};
                end
                remv_pkg::OP_DIV: begin
                    n_rem = w_fits ? w_diff[CW-1:0] : w_trial[CW-1:0];
                    n_sh  = {r_sh[DW-2:0], w_fits};
                end
                default: n_sh = r_sh;
            endcase
            n_iter = r_iter + 1'b1;
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter  <= n_iter;
        r_op    <= n_op;
        r_acc   <= n_acc;
        r_sh    <= n_sh;
        r_mcand <= n_mcand;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
    end

    assign o_sts.done = r_done;
    assign o_sts.ovf  = r_ovf;
    assign o_res      = (r_op == remv_pkg::OP_SQR) ? r_acc : PW'(r_sh);

endmodule

### hw/rtl/running_error_mean_variance_top.sv
// ----------------------------------------------------------------------------
// running_error_mean_variance_top
// Running mean and unbiased variance of the x/y position error between a
// reference and a measured track. The first sample after reset latches the
// reference origin, loads the means with the measured position and both
// variances with the initial variance register. For every later sample,
// per axis the shared square/divide unit runs a square and three divisions
// (by n, by n-1 and by n again), one bit per cycle, and the input is not
// ready during that time. A finished word waits in the output register
// while the next sample is taken. The saturated flag in tuser marks any
// clipped initial variance, error, term, sum or a sample count stuck at
// its maximum.
// ----------------------------------------------------------------------------
module running_error_mean_variance_top #(
    parameter int DATA_WIDTH = remv_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = remv_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: initial variance, unsigned
    input  logic                               i_cfg_wr_en,
    input  logic [remv_pkg::CFG_W-1:0]         i_cfg_wr_data,
    // input word
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // ref_x, ref_y, meas_x, meas_y (from bit 0 up)
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    // output word
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // var_x, var_y, mean_x, mean_y (from bit 0 up)
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    // saturated
    output logic [0:0]                         m_axis_tuser
);

    localparam int DW   = DATA_WIDTH;
    localparam int PW   = 2 * DATA_WIDTH;
    localparam int CW   = remv_pkg::COUNT_W;
    localparam int GW   = remv_pkg::CFG_W;
    localparam int XW   = (DW > GW) ? DW : GW;
    localparam int TW   = ((4 * DATA_WIDTH + 7) / 8) * 8;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_ERR  = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_SQ   = 7'b0001000,
        ST_VAR  = 7'b0010000,
        ST_MEAN = 7'b0100000,
        ST_HOLD = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [GW-1:0]       r_iv;
    logic                r_axis, n_axis;
    logic                r_sat, n_sat;
    logic                r_out_valid, n_out_valid;
    remv_pkg::t_alu_ctl  r_alu_ctl, n_alu_ctl;
    logic [PW-1:0]       r_opa, n_opa;
    logic [CW-1:0]       r_opb, n_opb;

    logic [DW-1:0]       r_ref [2];
    logic [DW-1:0]       n_ref [2];
    logic [DW-1:0]       r_meas [2];
    logic [DW-1:0]       n_meas [2];
    logic [DW-1:0]       r_org [2];
    logic [DW-1:0]       n_org [2];
    logic [DW-1:0]       r_mean [2];
    logic [DW-1:0]       n_mean [2];
    logic [DW-1:0]       r_var [2];
    logic [DW-1:0]       n_var [2];
    logic [DW-1:0]       r_mag, n_mag;
    logic                r_neg, n_neg;
    logic [DW-1:0]       r_t1, n_t1;
    logic [DW-1:0]       r_t2, n_t2;
    logic [4*DW-1:0]     r_out_data, n_out_data;
    logic                r_out_sat, n_out_sat;

    logic                w_s_acc;
    logic                w_m_acc;
    logic                w_cnt_max;
    logic [CW-1:0]       w_cnt_next;
    logic [XW-1:0]       w_iv_x;
    logic                w_iv_sat;
    logic [DW-1:0]       w_iv;
    logic [DW-1:0]       w_sel_ref, w_sel_meas, w_sel_org, w_sel_mean, w_sel_var;
    logic [DW:0]         w_rel;
    logic [DW+1:0]       w_err_w;
    logic                w_err_sat;
    logic [DW-1:0]       w_err;
    logic [DW:0]         w_d;
    logic [DW:0]         w_d_abs;
    logic [PW-1:0]       w_sq_sh;
    logic [DW:0]         w_sum;
    logic [DW-1:0]       w_q;

    remv_pkg::t_alu_sts  w_alu_sts;
    logic [PW-1:0]       w_alu_res;

    remv_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_alu_ctl),
        .i_opa   (r_opa),
        .i_opb   (r_opb),
        .o_sts   (w_alu_sts),
        .o_res   (w_alu_res)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc       = s_axis_tvalid & s_axis_tready;
    assign w_m_acc       = r_out_valid & m_axis_tready;

    assign w_cnt_max  = (r_cnt == {CW{1'b1}});
    assign w_cnt_next = w_cnt_max ? r_cnt : r_cnt + 1'b1;

    // initial variance clipped to the word when the word is narrower
    assign w_iv_x   = XW'(r_iv);
    assign w_iv_sat = (w_iv_x > XW'({DW{1'b1}}));
    assign w_iv     = w_iv_sat ? {DW{1'b1}} : w_iv_x[DW-1:0];

    assign w_sel_ref  = r_ref[r_axis];
    assign w_sel_meas = r_meas[r_axis];
    assign w_sel_org  = r_org[r_axis];
    assign w_sel_mean = r_mean[r_axis];
    assign w_sel_var  = r_var[r_axis];

    // error = meas - (ref - origin), clipped to the signed word
    assign w_rel     = {w_sel_ref[DW-1], w_sel_ref} - {w_sel_org[DW-1], w_sel_org};
    assign w_err_w   = {{2{w_sel_meas[DW-1]}}, w_sel_meas} - {w_rel[DW], w_rel};
    assign w_err_sat = ~((&w_err_w[DW+1:DW-1]) | ~(|w_err_w[DW+1:DW-1]));
    assign w_err     = !w_err_sat ? w_err_w[DW-1:0] :
                       w_err_w[DW+1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};

    assign w_d     = {w_err[DW-1], w_err} - {w_sel_mean[DW-1], w_sel_mean};
    assign w_d_abs = w_d[DW] ? (~w_d + 1'b1) : w_d;

    assign w_sq_sh = w_alu_res >> FRAC_BITS;
    assign w_q     = w_alu_res[DW-1:0];
    assign w_sum   = {1'b0, r_t1} + {1'b0, r_t2};

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_axis      = r_axis;
        n_sat       = r_sat;
        n_out_valid = r_out_valid & ~w_m_acc;
        n_alu_ctl   = '{start: 1'b0, op: r_alu_ctl.op};
        n_opa       = r_opa;
        n_opb       = r_opb;
        n_ref       = r_ref;
        n_meas      = r_meas;
        n_org       = r_org;
        n_mean      = r_mean;
        n_var       = r_var;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_out_data  = r_out_data;
        n_out_sat   = r_out_sat;

        case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_cnt     = w_cnt_next;
                    n_ref[0]  = s_axis_tdata[DW-1:0];
                    n_ref[1]  = s_axis_tdata[2*DW-1:DW];
                    n_meas[0] = s_axis_tdata[3*DW-1:2*DW];
                    n_meas[1] = s_axis_tdata[4*DW-1:3*DW];
                    n_axis    = 1'b0;
                    if (r_cnt == '0) begin
                        // first sample: latch origin, seed mean and variance
                        n_org[0]  = s_axis_tdata[DW-1:0];
                        n_org[1]  = s_axis_tdata[2*DW-1:DW];
                        n_mean[0] = s_axis_tdata[3*DW-1:2*DW];
                        n_mean[1] = s_axis_tdata[4*DW-1:3*DW];
                        n_var[0]  = w_iv;
                        n_var[1]  = w_iv;
                        n_sat     = w_iv_sat;
                        n_state   = ST_HOLD;
                    end else begin
                        n_sat   = w_cnt_max;
                        n_state = ST_ERR;
                    end
                end
            end
            ST_ERR: begin
                n_sat     = r_sat | w_err_sat;
                n_mag     = w_d_abs[DW-1:0];
                n_neg     = w_d[DW];
                n_alu_ctl = '{start: 1'b1, op: remv_pkg::OP_SQR};
                n_opa     = PW'(w_d_abs[DW-1:0]);
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                if (w_alu_sts.done) begin
                    n_alu_ctl = '{start: 1'b1, op: remv_pkg::OP_DIV};
                    n_opa     = w_sq_sh;
                    n_opb     = r_cnt;
                    n_state   = ST_SQ;
                end
            end
            ST_SQ: begin
                if (w_alu_sts.done) begin
                    n_t2      = w_alu_sts.ovf ? {DW{1'b1}} : w_q;
                    n_sat     = r_sat | w_alu_sts.ovf;
                    n_alu_ctl = '{start: 1'b1, op: remv_pkg::OP_DIV};
                    n_opa     = PW'(w_sel_var);
                    n_opb     = r_cnt - 1'b1;
                    n_state   = ST_VAR;
                end
            end
            ST_VAR: begin
                if (w_alu_sts.done) begin
                    n_t1      = w_sel_var - w_q;
                    n_alu_ctl = '{start: 1'b1, op: remv_pkg::OP_DIV};
                    n_opa     = PW'(r_mag);
                    n_opb     = r_cnt;
                    n_state   = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (w_alu_sts.done) begin
                    n_var[r_axis]  = w_sum[DW] ? {DW{1'b1}} : w_sum[DW-1:0];
                    n_sat          = r_sat | w_sum[DW];
                    // step toward the error, truncated toward zero
                    n_mean[r_axis] = r_neg ? (w_sel_mean - w_q) : (w_sel_mean + w_q);
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_state = ST_ERR;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_mean[1], r_mean[0], r_var[1], r_var[0]};
                    n_out_sat   = r_sat;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_iv        <= '0;
            r_out_valid <= 1'b0;
            r_alu_ctl   <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_alu_ctl   <= n_alu_ctl;
            if (i_cfg_wr_en) begin
                r_iv <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis     <= n_axis;
        r_sat      <= n_sat;
        r_opa      <= n_opa;
        r_opb      <= n_opb;
        r_ref      <= n_ref;
        r_meas     <= n_meas;
        r_org      <= n_org;
        r_mean     <= n_mean;
        r_var      <= n_var;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_t1       <= n_t1;
        r_t2       <= n_t2;
        r_out_data <= n_out_data;
        r_out_sat  <= n_out_sat;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TW'(r_out_data);
    assign m_axis_tuser  = r_out_sat;

    // count moves up by one per word and sticks at its maximum
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_cnt == $past(r_cnt) + 1'b1) ||
                    ($past(r_cnt) == {CW{1'b1}} && r_cnt == {CW{1'b1}}))
        else $error("sample count did not advance correctly");

    // the first word after reset needs no arithmetic
    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && r_cnt == '0) |=> (r_state == ST_HOLD))
        else $error("first word did not go straight to output");

    // the unit is only started on entry to a wait state
    a_alu_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alu_ctl.start |-> (r_state == ST_MUL || r_state == ST_SQ ||
                             r_state == ST_VAR || r_state == ST_MEAN))
        else $error("shared unit started outside a wait state");

    // a finished operation is always awaited by the sequencer
    a_alu_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_sts.done |-> (r_state == ST_MUL || r_state == ST_SQ ||
                            r_state == ST_VAR || r_state == ST_MEAN))
        else $error("shared unit finished while nothing waits for it");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// testbench
// Self-checking test of running_error_mean_variance_top. Position samples
// stream into the slave port. An in-bench model of the recursive error mean
// and unbiased variance predicts every output word, and each word is compared
// field by field. Directed corner samples come first. Random phases follow,
// built from tracks with small errors mixed with raw random words, with
// random gaps on both ports in every other phase. The initial variance
// register is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DW      = remv_pkg::DATA_WIDTH_DEF;
    localparam int FB      = remv_pkg::FRAC_BITS_DEF;
    localparam int TDW     = ((4*DW+7)/8)*8;
    localparam int LIMIT   = 5_000_000;
    localparam int DRAIN   = 400;
    localparam int PHASES  = 6;
    localparam int PHASE_N = 190;

    localparam logic signed [63:0] WMAX = (64'sd1 <<< (DW-1)) - 64'sd1;
    localparam logic signed [63:0] WMIN = -WMAX - 64'sd1;
    localparam logic [63:0]        UMAX = (64'd1 << DW) - 64'd1;
    localparam logic [DW-1:0]      POS_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]      POS_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic [DW-1:0] var_x;
        logic [DW-1:0] var_y;
        logic [DW-1:0] mean_x;
        logic [DW-1:0] mean_y;
        logic          saturated;
    } t_stats;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_wr_en = 1'b0;
    logic [remv_pkg::CFG_W-1:0] i_cfg_wr_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // ref_x, ref_y, meas_x, meas_y (from bit 0 up)
    logic [TDW-1:0]             s_axis_tdata = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // var_x, var_y, mean_x, mean_y (from bit 0 up)
    logic [TDW-1:0]             m_axis_tdata;
    // saturated
    logic [0:0]                 m_axis_tuser;

    // model state
    logic [remv_pkg::COUNT_W-1:0] n_samples = '0;
    logic signed [63:0] origin [2]   = '{64'sd0, 64'sd0};
    logic signed [63:0] err_mean [2] = '{64'sd0, 64'sd0};
    logic [63:0]        err_var [2]  = '{64'd0, 64'd0};
    logic [remv_pkg::CFG_W-1:0] init_var_copy = '0;
    logic               step_saturated;

    logic [TDW-1:0]     samples_to_send [$];
    t_stats             stats_due [$];
    t_stats             got, want;
    logic signed [63:0] track [2] = '{64'sd0, 64'sd0};
    int                 mismatches = 0;
    int                 words_seen = 0;
    int                 cycle_count = 0;
    int                 in_gap = 0;
    int                 out_stall = 0;
    bit                 idle_on = 1'b0;

    running_error_mean_variance_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    function automatic logic signed [63:0] clip_to_word(logic signed [63:0] v);
        if (v > WMAX) begin
            step_saturated = 1'b1;
            return WMAX;
        end
        if (v < WMIN) begin
            step_saturated = 1'b1;
            return WMIN;
        end
        return v;
    endfunction

    // one axis of sample n >= 2
    function automatic void fold_axis_error(int ax, logic signed [63:0] e, logic [63:0] n);
        logic signed [63:0] d;
        logic [63:0]        mag, decayed, spread, step, total;
        logic [127:0]       sq;
        d       = e - err_mean[ax];
        mag     = (d < 0) ? -d : d;
        decayed = err_var[ax] - err_var[ax] / (n - 64'd1);
        sq      = {64'd0, mag} * {64'd0, mag};
        sq      = (sq >> FB) / {64'd0, n};
        if (sq > {64'd0, UMAX}) begin
            step_saturated = 1'b1;
            spread = UMAX;
        end else begin
            spread = sq[63:0];
        end
        total = decayed + spread;
        if (total > UMAX) begin
            step_saturated = 1'b1;
            total = UMAX;
        end
        err_var[ax] = total;
        // truncation toward zero keeps the mean between old mean and error
        step = mag / n;
        err_mean[ax] = (d < 0) ? err_mean[ax] - $signed(step) : err_mean[ax] + $signed(step);
    endfunction

    function automatic void advance_error_stats(logic [TDW-1:0] w);
        logic signed [63:0] pos [4];
        t_stats             s;
        int                 k;
        for (k = 0; k < 4; k++) begin
            pos[k] = $signed(w[k*DW +: DW]);
        end
        step_saturated = 1'b0;
        if (n_samples == '1) begin
            step_saturated = 1'b1;
        end else begin
            n_samples = n_samples + 1'b1;
        end
        if (n_samples == 1) begin
            origin[0]   = pos[0];
            origin[1]   = pos[1];
            err_mean[0] = clip_to_word(pos[2]);
            err_mean[1] = clip_to_word(pos[3]);
            err_var[0]  = init_var_copy;
            err_var[1]  = init_var_copy;
        end else begin
            fold_axis_error(0, clip_to_word(pos[2] - (pos[0] - origin[0])), n_samples);
            fold_axis_error(1, clip_to_word(pos[3] - (pos[1] - origin[1])), n_samples);
        end
        s.var_x     = err_var[0][DW-1:0];
        s.var_y     = err_var[1][DW-1:0];
        s.mean_x    = err_mean[0][DW-1:0];
        s.mean_y    = err_mean[1][DW-1:0];
        s.saturated = step_saturated;
        stats_due.push_back(s);
    endfunction

    function automatic int pick_gap(int long_max);
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(8, long_max);
    endfunction

    // uniform in [-2^nb, 2^nb]
    function automatic logic signed [63:0] centered(int nb);
        return $signed({32'd0, $urandom_range(0, 2 << nb)}) - (64'sd1 <<< nb);
    endfunction

    function automatic void push_sample(logic [DW-1:0] rx, ry, mx, my);
        samples_to_send.push_back({my, mx, ry, rx});
    endfunction

    // mostly a smooth track with small errors, some raw words
    task automatic push_random_sample(int nb);
        logic signed [63:0] refp [2];
        logic signed [63:0] meas [2];
        int                 ax;
        if ($urandom_range(0, 99) < 12) begin
            push_sample($urandom, $urandom, $urandom, $urandom);
            return;
        end
        for (ax = 0; ax < 2; ax++) begin
            track[ax] = track[ax] + centered(17);
            if (track[ax] > 64'sd1073741824 || track[ax] < -64'sd1073741824) begin
                track[ax] = 64'sd0;
            end
            refp[ax] = origin[ax] + track[ax];
            if (refp[ax] > WMAX || refp[ax] < WMIN) begin
                refp[ax] = origin[ax] - track[ax];
            end
            meas[ax] = refp[ax] - origin[ax] + centered(nb);
            // rare outlier
            if ($urandom_range(0, 99) < 3) begin
                meas[ax] = meas[ax] + centered(27);
            end
        end
        push_sample(refp[0][DW-1:0], refp[1][DW-1:0], meas[0][DW-1:0], meas[1][DW-1:0]);
    endtask

    task automatic write_init_var(logic [remv_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        init_var_copy = value;
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (samples_to_send.size() != 0 || s_axis_tvalid || stats_due.size() != 0);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_error_stats(s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (samples_to_send.size() > 0) begin
                    s_axis_tdata  <= samples_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    in_gap = pick_gap(300);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                words_seen++;
                got.var_x     = m_axis_tdata[0*DW +: DW];
                got.var_y     = m_axis_tdata[1*DW +: DW];
                got.mean_x    = m_axis_tdata[2*DW +: DW];
                got.mean_y    = m_axis_tdata[3*DW +: DW];
                got.saturated = m_axis_tuser[0];
                if (stats_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("word %0d unexpected: var %h/%h mean %h/%h sat %b",
                                 words_seen, got.var_x, got.var_y, got.mean_x,
                                 got.mean_y, got.saturated);
                    end
                end else begin
                    want = stats_due.pop_front();
                    if (got.var_x !== want.var_x || got.var_y !== want.var_y ||
                        got.mean_x !== want.mean_x || got.mean_y !== want.mean_y ||
                        got.saturated !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("word %0d expected var %h/%h mean %h/%h sat %b",
                                     words_seen, want.var_x, want.var_y, want.mean_x,
                                     want.mean_y, want.saturated);
                            $display("word %0d actual   var %h/%h mean %h/%h sat %b",
                                     words_seen, got.var_x, got.var_y, got.mean_x,
                                     got.mean_y, got.saturated);
                        end
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 99) < 3) begin
                    out_stall = pick_gap(300);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin
        int                         ph, k, nb;
        logic [remv_pkg::CFG_W-1:0] iv;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        case ($urandom_range(0, 2))
            0: iv = '1;
            1: iv = $urandom;
            default: iv = remv_pkg::CFG_W'($urandom_range(1, 255)) << FB;
        endcase
        write_init_var(iv);
        @(negedge i_clk);
        idle_on = 1'b1;
        // first sample: origin at the corners, error is the measured position
        push_sample(POS_MIN, POS_MAX, 32'h0001_8000, 32'hFFFF_0000);
        // errors landing exactly on the signed limits
        push_sample('0, '0, '0, '0);
        // errors far out of range on both sides
        push_sample(POS_MAX, POS_MIN, POS_MIN, POS_MAX);
        push_sample(POS_MAX, POS_MIN, POS_MAX, POS_MIN);
        push_sample('1, '1, '1, '1);
        push_sample(POS_MIN, POS_MAX, POS_MAX, POS_MIN);
        push_sample(POS_MIN, POS_MAX, 32'h5555_5555, 32'hAAAA_AAAA);
        push_sample(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFF);
        // back on the origin with small errors of both signs
        for (k = 0; k < 12; k++) begin
            push_sample(POS_MIN, POS_MAX, DW'(k << 12), DW'(-(k << 12)));
        end
        for (ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph % 3)
                0: iv = '0;
                1: iv = '1;
                default: iv = $urandom;
            endcase
            write_init_var(iv);
            @(negedge i_clk);
            idle_on = (ph % 2 == 1);
            nb = $urandom_range(4, 24);
            for (k = 0; k < PHASE_N; k++) begin
                push_random_sample(nb);
            end
        end
        wait_idle();
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && stats_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
